### hdl/detection_dedup_table_core_macros.svh
// assertion helpers for the dedup table core
`ifndef DETECTION_DEDUP_TABLE_CORE_MACROS_SVH
`define DETECTION_DEDUP_TABLE_CORE_MACROS_SVH

// same-cycle implication on the core clock
`define DDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dedup table core check failed");

// next-cycle implication on the core clock
`define DDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dedup table core check failed");

`endif

### hdl/ddt_pkg.sv
`timescale 1ns / 1ps
package ddt_pkg;

   localparam int TABLE_DEPTH  = 128;
   localparam int IGNORE_DEPTH = 32;

   localparam int TBL_AW = $clog2(TABLE_DEPTH);
   localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);
   localparam int IGN_AW = (IGNORE_DEPTH > 1) ? $clog2(IGNORE_DEPTH) : 1;
   localparam int IGN_CW = $clog2(IGNORE_DEPTH + 1);

   localparam logic [31:0] WINDOW_RESET = 32'd60000;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   localparam int CSR_IW = 4;
   localparam logic [CSR_IW-1:0] CSR_DEDUP_WINDOW = 4'd0;
   localparam logic [CSR_IW-1:0] CSR_IGNORE_COUNT = 4'd1;

   localparam logic OP_DETECT    = 1'b0;
   localparam logic OP_IGNORE_WR = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  device_type;
      logic [47:0] station_mac;
      logic [47:0] dedup_key;
      logic [31:0] now_ms;
      logic [4:0]  ignore_index;
   } req_payload_type;

   typedef struct packed {
      logic        dropped;
      logic        is_new;
      logic [31:0] first_seen;
      logic [31:0] last_seen;
      logic [15:0] sighting_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0]  dev_type;
      logic [47:0] key;
      logic [31:0] first;
      logic [31:0] last;
      logic [15:0] count;
   } tbl_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IGN_WR,
      ST_IGN_SCAN,
      ST_TBL_SCAN,
      ST_CLAIM,
      ST_UPDATE,
      ST_DROP
   } state_type;

endpackage

### hdl/detection_dedup_table_core.sv
`timescale 1ns / 1ps
// detection dedup table core
// req channel: one beat per item (detection or ignore-list write), taken when
//   req_valid is high and req_stall is low; req_stall stays high while an item
//   is in flight, so one item is worked on at a time
// rsp channel: exactly one beat per item from an output register; the next
//   item is taken while a result still waits on rsp_stall
// csr channel: dedup_window (index 0) and ignore_count (index 1), always ready
// ignore-list write: the result is loaded from ST_IGN_WR once the output register is free
// detection: the ignore list is read one slot a cycle until a hit, up to
//   ignore_count slots (at most IGNORE_DEPTH), then the table memory one entry
//   a cycle until a match or up to TABLE_DEPTH entries, then ST_CLAIM on a
//   miss and the ST_UPDATE write-back; each memory has a single read port
// the next item can be taken in the cycle after the result is loaded, so one
//   item is worked on at a time
// a dropped detection leaves the table untouched
// reset: synchronous; clears all entry valid bits at once, loads the
//   register defaults, empties the output register; no clearing pass
// a stalled result holds the block at its final step until the beat is taken
module detection_dedup_table_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ddt_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ddt_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ddt_pkg::CSR_IW-1:0] csr_index,
   input  logic [31:0]              csr_wdata
);
   import ddt_pkg::*;

   state_type        state_ff, state_in;
   req_payload_type  item_ff, item_in;
   logic [31:0]      window_ff;
   logic [5:0]       icount_ff;

   logic [IGN_CW-1:0] ign_cnt_ff, ign_cnt_in;
   logic              ign_pend_ff, ign_pend_in;
   logic [TBL_CW-1:0] tbl_cnt_ff, tbl_cnt_in;
   logic              tbl_pend_ff, tbl_pend_in;
   logic [TBL_AW-1:0] tbl_didx_ff, tbl_didx_in;
   logic              have_free_ff, have_free_in;
   logic [TBL_AW-1:0] free_idx_ff, free_idx_in;
   logic              have_old_ff, have_old_in;
   logic [TBL_AW-1:0] old_idx_ff, old_idx_in;
   logic [31:0]       old_last_ff, old_last_in;
   logic [TBL_AW-1:0] slot_ff, slot_in;
   tbl_entry_type     ent_ff, ent_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [IGN_CW-1:0] ign_lim;
   logic [47:0]       ign_rdata;
   tbl_entry_type     tbl_rdata;
   tbl_entry_type     ent_next;
   rsp_payload_type   upd_result;
   logic              req_acc, out_free;
   logic              ign_hit, ign_done, tbl_hit, tbl_done;
   logic              ign_we, tbl_we, rsp_load;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ign_lim  = (32'(icount_ff) > IGNORE_DEPTH) ? IGN_CW'(IGNORE_DEPTH)
                                                     : IGN_CW'(icount_ff);

   assign ign_hit  = ign_pend_ff && (ign_rdata == item_ff.station_mac);
   assign ign_done = (ign_cnt_ff == ign_lim) && !ign_pend_ff;
   assign tbl_hit  = tbl_pend_ff && valid_ff[tbl_didx_ff]
                     && (tbl_rdata.dev_type == item_ff.device_type)
                     && (tbl_rdata.key == item_ff.dedup_key);
   assign tbl_done = (32'(tbl_cnt_ff) == TABLE_DEPTH) && !tbl_pend_ff;

   ddt_ram #(
      .WIDTH (48),
      .DEPTH (IGNORE_DEPTH)
   ) u_ign_ram (
      .clock (clock),
      .we    (ign_we),
      .waddr (IGN_AW'(item_ff.ignore_index)),
      .wdata (item_ff.station_mac),
      .raddr (ign_cnt_ff[IGN_AW-1:0]),
      .rdata (ign_rdata)
   );

   ddt_ram #(
      .WIDTH ($bits(tbl_entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (slot_ff),
      .wdata (ent_next),
      .raddr (tbl_cnt_ff[TBL_AW-1:0]),
      .rdata (tbl_rdata)
   );

   ddt_update u_update (
      .ent      (ent_ff),
      .now_ms   (item_ff.now_ms),
      .window   (window_ff),
      .ent_next (ent_next),
      .result   (upd_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_data.opcode == OP_IGNORE_WR) ? ST_IGN_WR : ST_IGN_SCAN;
            end
         end
         ST_IGN_SCAN: begin
            if (ign_hit) begin
               state_in = ST_DROP;
            end else if (ign_done) begin
               state_in = ST_TBL_SCAN;
            end
         end
         ST_TBL_SCAN: begin
            if (tbl_hit) begin
               state_in = ST_UPDATE;
            end else if (tbl_done) begin
               state_in = ST_CLAIM;
            end
         end
         ST_CLAIM: state_in = ST_UPDATE;
         ST_IGN_WR, ST_UPDATE, ST_DROP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      ign_we    = 1'b0;
      tbl_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_IGN_WR: begin
            ign_we   = out_free && (32'(item_ff.ignore_index) < IGNORE_DEPTH);
            rsp_load = out_free;
         end
         ST_UPDATE: begin
            tbl_we   = out_free;
            rsp_load = out_free;
         end
         ST_DROP:   rsp_load = out_free;
         default: ;
      endcase
   end

   // scan and result datapath
   always_comb begin
      item_in      = item_ff;
      ign_cnt_in   = ign_cnt_ff;
      ign_pend_in  = ign_pend_ff;
      tbl_cnt_in   = tbl_cnt_ff;
      tbl_pend_in  = tbl_pend_ff;
      tbl_didx_in  = tbl_didx_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      have_old_in  = have_old_ff;
      old_idx_in   = old_idx_ff;
      old_last_in  = old_last_ff;
      slot_in      = slot_ff;
      ent_in       = ent_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               item_in      = req_data;
               ign_cnt_in   = '0;
               ign_pend_in  = 1'b0;
               tbl_cnt_in   = '0;
               tbl_pend_in  = 1'b0;
               have_free_in = 1'b0;
               have_old_in  = 1'b0;
            end
         end
         ST_IGN_SCAN: begin
            if (!ign_hit) begin
               if (ign_cnt_ff < ign_lim) begin
                  ign_cnt_in  = ign_cnt_ff + IGN_CW'(1);
                  ign_pend_in = 1'b1;
               end else begin
                  ign_pend_in = 1'b0;
               end
            end
         end
         ST_TBL_SCAN: begin
            if (tbl_hit) begin
               ent_in  = tbl_rdata;
               slot_in = tbl_didx_ff;
            end else begin
               if (tbl_pend_ff && valid_ff[tbl_didx_ff]) begin
                  if (!have_old_ff || (tbl_rdata.last < old_last_ff)) begin
                     have_old_in = 1'b1;
                     old_idx_in  = tbl_didx_ff;
                     old_last_in = tbl_rdata.last;
                  end
               end else if (tbl_pend_ff && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = tbl_didx_ff;
               end
               if (32'(tbl_cnt_ff) < TABLE_DEPTH) begin
                  tbl_cnt_in  = tbl_cnt_ff + TBL_CW'(1);
                  tbl_pend_in = 1'b1;
                  tbl_didx_in = tbl_cnt_ff[TBL_AW-1:0];
               end else begin
                  tbl_pend_in = 1'b0;
               end
            end
         end
         ST_CLAIM: begin
            slot_in         = have_free_ff ? free_idx_ff : old_idx_ff;
            ent_in.dev_type = item_ff.device_type;
            ent_in.key      = item_ff.dedup_key;
            ent_in.first    = '0;
            ent_in.last     = '0;
            ent_in.count    = '0;
         end
         ST_UPDATE: begin
            if (tbl_we) begin
               valid_in[slot_ff] = 1'b1;
            end
            if (rsp_load) begin
               rsp_in = upd_result;
            end
         end
         ST_DROP: begin
            if (rsp_load) begin
               rsp_in         = '0;
               rsp_in.dropped = 1'b1;
            end
         end
         ST_IGN_WR: begin
            if (rsp_load) begin
               rsp_in = '0;
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ign_pend_ff  <= 1'b0;
         tbl_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ign_pend_ff  <= ign_pend_in;
         tbl_pend_ff  <= tbl_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      ign_cnt_ff   <= ign_cnt_in;
      tbl_cnt_ff   <= tbl_cnt_in;
      tbl_didx_ff  <= tbl_didx_in;
      have_free_ff <= have_free_in;
      free_idx_ff  <= free_idx_in;
      have_old_ff  <= have_old_in;
      old_idx_ff   <= old_idx_in;
      old_last_ff  <= old_last_in;
      slot_ff      <= slot_in;
      ent_ff       <= ent_in;
      rsp_ff       <= rsp_in;
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         icount_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEDUP_WINDOW: window_ff <= csr_wdata;
            CSR_IGNORE_COUNT: icount_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "detection_dedup_table_core_macros.svh"

   `DDT_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall)
   `DDT_ASSERT_NOW(a_drop_clean, rsp_valid && rsp_data.dropped,
      !rsp_data.is_new && (rsp_data.sighting_count == 16'd0))
   `DDT_ASSERT_NOW(a_first_is_new, rsp_valid && (rsp_data.sighting_count == 16'd1),
      rsp_data.is_new)
   `DDT_ASSERT_NOW(a_write_back_free, tbl_we, !ign_we && (state_ff == ST_UPDATE))

endmodule

### hdl/ddt_ram.sv
`timescale 1ns / 1ps
module ddt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/ddt_update.sv
`timescale 1ns / 1ps
module ddt_update (
   input  ddt_pkg::tbl_entry_type   ent,
   input  logic [31:0]              now_ms,
   input  logic [31:0]              window,
   output ddt_pkg::tbl_entry_type   ent_next,
   output ddt_pkg::rsp_payload_type result
);
   import ddt_pkg::*;

   logic        first_hit;
   logic [31:0] gap;
   logic        fresh;

   always_comb begin
      first_hit = (ent.count == 16'd0);
      gap       = now_ms - ent.last;
      fresh     = first_hit || (gap > window);

      ent_next          = ent;
      ent_next.first    = first_hit ? now_ms : ent.first;
      ent_next.last     = now_ms;
      ent_next.count    = (ent.count == COUNT_MAX) ? ent.count : ent.count + 16'd1;

      result.dropped        = 1'b0;
      result.is_new         = fresh;
      result.first_seen     = ent_next.first;
      result.last_seen      = ent_next.last;
      result.sighting_count = ent_next.count;
   end

endmodule

### sim/tb_detection_dedup_table_core.sv
`timescale 1ns / 1ps
module tb_detection_dedup_table_core;
   import ddt_pkg::*;

   class dedup_mirror;
      logic            used [TABLE_DEPTH];
      logic [3:0]      kind [TABLE_DEPTH];
      logic [47:0]     ident [TABLE_DEPTH];
      logic [31:0]     first_ms [TABLE_DEPTH];
      logic [31:0]     last_ms [TABLE_DEPTH];
      logic [15:0]     seen [TABLE_DEPTH];
      logic [47:0]     blocked [IGNORE_DEPTH];
      logic [31:0]     window_ms;
      logic [5:0]      ignore_limit;
      rsp_payload_type pending_reports [$];
      int              mismatches;

      function new();
         window_ms = WINDOW_RESET;
         ignore_limit = '0;
         mismatches = 0;
         foreach (used[i]) begin
            used[i] = 1'b0;
            kind[i] = '0;
            ident[i] = '0;
            first_ms[i] = '0;
            last_ms[i] = '0;
            seen[i] = '0;
         end
         foreach (blocked[i]) blocked[i] = '0;
      endfunction

      function void set_register(logic [CSR_IW-1:0] idx, logic [31:0] val);
         if (idx == CSR_DEDUP_WINDOW) window_ms = val;
         else if (idx == CSR_IGNORE_COUNT) ignore_limit = val[5:0];
      endfunction

      function void absorb_item(req_payload_type it);
         rsp_payload_type r;
         int              lim;
         int              slot;
         int              free_slot;
         int              old_slot;
         bit              found;
         bit              dropped;
         logic [31:0]     gap;
         r = '0;
         if (it.opcode == OP_IGNORE_WR) begin
            blocked[it.ignore_index] = it.station_mac;
         end else begin
            lim = (ignore_limit > IGNORE_DEPTH) ? IGNORE_DEPTH : int'(ignore_limit);
            dropped = 1'b0;
            for (int i = 0; i < lim; i++)
               if (blocked[i] == it.station_mac) dropped = 1'b1;
            if (dropped) begin
               r.dropped = 1'b1;
            end else begin
               found = 1'b0;
               slot = 0;
               free_slot = -1;
               old_slot = -1;
               for (int i = 0; i < TABLE_DEPTH && !found; i++) begin
                  if (used[i]) begin
                     if (kind[i] == it.device_type && ident[i] == it.dedup_key) begin
                        slot = i;
                        found = 1'b1;
                     end else if (old_slot < 0 || last_ms[i] < last_ms[old_slot]) begin
                        old_slot = i;
                     end
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (!found) begin
                  slot = (free_slot >= 0) ? free_slot : old_slot;
                  used[slot] = 1'b1;
                  kind[slot] = it.device_type;
                  ident[slot] = it.dedup_key;
                  first_ms[slot] = '0;
                  last_ms[slot] = '0;
                  seen[slot] = '0;
               end
               gap = it.now_ms - last_ms[slot];
               r.is_new = (seen[slot] == 0) || (gap > window_ms);
               if (seen[slot] == 0) first_ms[slot] = it.now_ms;
               last_ms[slot] = it.now_ms;
               if (seen[slot] != COUNT_MAX) seen[slot] = seen[slot] + 16'd1;
               r.first_seen = first_ms[slot];
               r.last_seen = last_ms[slot];
               r.sighting_count = seen[slot];
            end
         end
         pending_reports.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_report(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_reports.size() == 0) begin
            $error("result beat with nothing outstanding");
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         check_field("dropped", 32'(want.dropped), 32'(got.dropped));
         check_field("is_new", 32'(want.is_new), 32'(got.is_new));
         check_field("first_seen", want.first_seen, got.first_seen);
         check_field("last_seen", want.last_seen, got.last_seen);
         check_field("sighting_count", 32'(want.sighting_count), 32'(got.sighting_count));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_payload_type    req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_payload_type    rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_IW-1:0]  csr_index;
   logic [31:0]        csr_wdata;

   dedup_mirror        tracker;
   bit                 stall_pattern_on;
   bit                 hold_off_request;
   logic [31:0]        clock_ms;
   logic [3:0]         pool_type [$];
   logic [47:0]        pool_key [$];
   logic [3:0]         prev_type;
   logic [47:0]        prev_key;
   bit                 prev_valid;

   detection_dedup_table_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_report(rsp_data);
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int seg_left;
      int seg_kind;
      seg_left = 0;
      seg_kind = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end else if (!stall_pattern_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 3);
               seg_left = $urandom_range(4, 50);
            end
            seg_left--;
            case (seg_kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 6);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   function automatic logic [47:0] rand48();
      logic [47:0] v;
      v[47:32] = 16'($urandom);
      v[31:0] = $urandom;
      return v;
   endfunction

   task automatic send_item(req_payload_type it);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      tracker.absorb_item(it);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic detect(logic [3:0] t, logic [47:0] mac, logic [47:0] key, logic [31:0] now);
      req_payload_type it;
      it.opcode = OP_DETECT;
      it.device_type = t;
      it.station_mac = mac;
      it.dedup_key = key;
      it.now_ms = now;
      it.ignore_index = 5'($urandom);
      send_item(it);
   endtask

   task automatic ignore_write(logic [4:0] idx, logic [47:0] mac);
      req_payload_type it;
      it.opcode = OP_IGNORE_WR;
      it.device_type = 4'($urandom);
      it.station_mac = mac;
      it.dedup_key = rand48();
      it.now_ms = $urandom;
      it.ignore_index = idx;
      send_item(it);
   endtask

   function automatic req_payload_type random_item();
      req_payload_type it;
      logic [31:0]     delta;
      int              pick;
      it.opcode = OP_DETECT;
      it.device_type = 4'($urandom);
      it.station_mac = rand48();
      it.dedup_key = rand48();
      it.now_ms = $urandom;
      it.ignore_index = 5'($urandom);
      if ($urandom_range(0, 24) == 0) begin
         it.opcode = OP_IGNORE_WR;
         return it;
      end
      if (prev_valid && $urandom_range(0, 9) == 0) begin
         // same device again right at the window edge
         it.device_type = prev_type;
         it.dedup_key = prev_key;
         clock_ms = clock_ms + tracker.window_ms + $urandom_range(0, 1);
      end else begin
         pick = $urandom_range(0, pool_type.size() - 1);
         it.device_type = pool_type[pick];
         it.dedup_key = pool_key[pick];
         case ($urandom_range(0, 9))
            0, 1: delta = '0;
            2, 3, 4, 5: delta = $urandom_range(1, 1000);
            6: delta = $urandom_range(1000, 200000);
            7: delta = $urandom;
            default: delta = $urandom_range(0, 50);
         endcase
         clock_ms = clock_ms + delta;
      end
      it.now_ms = clock_ms;
      if ($urandom_range(0, 4) == 0)
         it.station_mac = tracker.blocked[$urandom_range(0, IGNORE_DEPTH - 1)];
      prev_type = it.device_type;
      prev_key = it.dedup_key;
      prev_valid = 1'b1;
      return it;
   endfunction

   task automatic run_phase(logic [31:0] window, logic [5:0] limit, int pool_n, int count,
                            bit hold);
      int burst_left;
      int src;
      wait_drained();
      write_csr(CSR_DEDUP_WINDOW, window);
      write_csr(CSR_IGNORE_COUNT, {26'd0, limit});
      pool_type.delete();
      pool_key.delete();
      for (int i = 0; i < pool_n; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            // same key under another device class
            src = $urandom_range(0, i - 1);
            pool_type.push_back(pool_type[src] + 4'd1);
            pool_key.push_back(pool_key[src]);
         end else begin
            pool_type.push_back(4'($urandom));
            pool_key.push_back(rand48());
         end
      end
      prev_valid = 1'b0;
      if (hold) hold_off_request = 1'b1;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 20));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         if ($urandom_range(0, 299) == 0) wait_drained();
         send_item(random_item());
      end
   endtask

   initial begin
      logic [31:0] t;
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_DEDUP_WINDOW;
      csr_wdata = '0;
      stall_pattern_on = 1'b0;
      hold_off_request = 1'b0;
      prev_valid = 1'b0;
      clock_ms = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load every ignore slot so any ignore count stays within written slots
      ignore_write(5'd0, 48'h0);
      for (int i = 1; i < IGNORE_DEPTH - 1; i++) ignore_write(i[4:0], rand48());
      ignore_write(5'd31, 48'hFFFF_FFFF_FFFF);

      // drive one entry into count saturation, time wrapping on the way
      t = 32'hFFFF_F000;
      for (int i = 0; i < 65537; i++) begin
         t = t + (((i % 4096) == 4095) ? 32'd70000 : $urandom_range(0, 3));
         detect(4'h3, rand48(), 48'h5A5A_0000_A5A5, t);
      end

      stall_pattern_on = 1'b1;
      detect(4'hF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      detect(4'h0, 48'h0, 48'h0, 32'h0);
      detect(4'hF, rand48(), 48'hFFFF_FFFF_FFFF, 32'h0000_EA5F);
      detect(4'hF, rand48(), 48'hFFFF_FFFF_FFFF, 32'd120000);
      detect(4'h0, rand48(), 48'hFFFF_FFFF_FFFF, 32'd120000);
      detect(4'h3, rand48(), 48'h5A5A_0000_A5A5, t + 32'd5);

      wait_drained();
      write_csr(CSR_IGNORE_COUNT, 32'd32);
      write_csr(CSR_DEDUP_WINDOW, 32'd0);
      detect(4'h7, 48'hFFFF_FFFF_FFFF, rand48(), $urandom);
      detect(4'h7, 48'h0, rand48(), $urandom);
      detect(4'h0, rand48(), 48'h0, 32'h0);
      detect(4'h0, rand48(), 48'h0, 32'h0);
      detect(4'h0, rand48(), 48'h0, 32'h1);
      ignore_write(5'd5, 48'h1234_5678_9ABC);
      detect(4'h2, 48'h1234_5678_9ABC, rand48(), $urandom);

      wait_drained();
      write_csr(CSR_IGNORE_COUNT, 32'd63);
      write_csr(CSR_DEDUP_WINDOW, 32'hFFFF_FFFF);
      detect(4'h9, 48'hFFFF_FFFF_FFFF, rand48(), $urandom);
      detect(4'hF, rand48(), 48'hFFFF_FFFF_FFFF, 32'h0);

      wait_drained();
      write_csr(CSR_IGNORE_COUNT, 32'd31);
      detect(4'hF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);

      clock_ms = $urandom;
      run_phase($urandom_range(0, 5000), 6'($urandom_range(0, 32)), 40, 250, 1'b0);
      run_phase(32'd0, 6'd0, 200, 300, 1'b0);
      run_phase(32'hFFFF_FFFF, 6'd63, 150, 250, 1'b1);
      run_phase(32'd60000, 6'd32, 20, 250, 1'b0);
      run_phase($urandom, 6'($urandom_range(0, 63)), 300, 300, 1'b0);
      run_phase(32'd1000, 6'd1, 129, 250, 1'b0);

      wait_drained();
      repeat (200) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/ddt_pkg.sv
hdl/ddt_ram.sv
hdl/ddt_update.sv
hdl/detection_dedup_table_core.sv
sim/tb_detection_dedup_table_core.sv
